/* src/fpmc_pkg.sv */
package fpmc_pkg;

    localparam int NUM_SWITCHES_DEF  = 7;
    localparam int SW_REG_COUNT      = 7;
    localparam int SW_IDX_W          = 4;
    localparam int CTRL_W            = 7;
    localparam int CHAN_W            = 4;
    localparam int CODE_W            = 10;
    localparam int VAL_W             = 16;
    localparam int OP_W              = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = SW_REG_COUNT * CTRL_W;
    localparam int FIRST_SWITCH_CODE = 2;
    localparam int PEDAL_AXIS        = 0;

    localparam int PEDAL_BASE  = 264;
    localparam int PEDAL_SPAN  = 3356;
    localparam int CC_MAX_I    = 127;
    localparam logic [CTRL_W-1:0] CC_MAX = CTRL_W'(CC_MAX_I);
    localparam logic [CTRL_W-1:0] CC_OFF = '0;

    localparam int DIFF_W      = VAL_W + 1;
    localparam int SPAN_W      = $clog2(PEDAL_SPAN);
    localparam int SCALE_SHIFT = 24;
    localparam longint SCALE_MULT_L =
        (longint'(CC_MAX_I) * (longint'(1) << SCALE_SHIFT) + longint'(PEDAL_SPAN) - 1)
        / longint'(PEDAL_SPAN);
    localparam int SCALE_MULT_W = $clog2(SCALE_MULT_L + 1);
    localparam int PROD_W       = SPAN_W + SCALE_MULT_W;

    typedef enum logic [OP_W-1:0] {
        OP_KEY  = 2'd0,
        OP_AXIS = 2'd1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIDI_CHANNEL = 3'd0,
        CFG_PEDAL_CTRL   = 3'd1,
        CFG_SW_CTRLS     = 3'd2,
        CFG_SW_TOGGLE    = 3'd3,
        CFG_SW_ENABLE    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0]       midi_channel;
        logic [CTRL_W-1:0]       pedal_ctrl;
        logic [CFG_DATA_W-1:0]   sw_ctrls;
        logic [SW_REG_COUNT-1:0] sw_toggle;
        logic [SW_REG_COUNT-1:0] sw_enable;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [CTRL_W-1:0] controller;
        logic [CTRL_W-1:0] cc_value;
    } t_result;

endpackage

/* src/fpmc_cfg_regs.sv */
module fpmc_cfg_regs
    import fpmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIDI_CHANNEL: r_cfg.midi_channel <= i_cfg_data[CHAN_W-1:0];
                CFG_PEDAL_CTRL:   r_cfg.pedal_ctrl   <= i_cfg_data[CTRL_W-1:0];
                CFG_SW_CTRLS:     r_cfg.sw_ctrls     <= i_cfg_data;
                CFG_SW_TOGGLE:    r_cfg.sw_toggle    <= i_cfg_data[SW_REG_COUNT-1:0];
                CFG_SW_ENABLE:    r_cfg.sw_enable    <= i_cfg_data[SW_REG_COUNT-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* src/fpmc_pedal_scale.sv */
module fpmc_pedal_scale
    import fpmc_pkg::*;
(
    input  logic signed [VAL_W-1:0] i_value,
    output logic [CTRL_W-1:0]       o_cc_value
);

    logic signed [DIFF_W-1:0]  w_diff;
    logic [PROD_W-1:0]         w_prod;

    assign w_diff = DIFF_W'(i_value) - DIFF_W'(PEDAL_BASE);
    assign w_prod = PROD_W'(w_diff[SPAN_W-1:0]) * PROD_W'(SCALE_MULT_L);

    always_comb begin
        if (w_diff < 0) begin
            o_cc_value = CC_OFF;
        end else if (w_diff >= DIFF_W'(PEDAL_SPAN)) begin
            o_cc_value = CC_MAX;
        end else begin
            o_cc_value = w_prod[SCALE_SHIFT +: CTRL_W];
        end
    end

endmodule

/* src/fpmc_event_core.sv */
module fpmc_event_core
    import fpmc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_fire,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [CODE_W-1:0]       i_event_code,
    input  logic signed [VAL_W-1:0] i_event_value,
    output t_result                 o_res
);

    logic [SW_REG_COUNT-1:0] r_toggle;
    logic [SW_REG_COUNT-1:0] n_toggle;
    logic signed [VAL_W-1:0] r_last;
    logic signed [VAL_W-1:0] n_last;

    logic                    w_key_range;
    logic [SW_IDX_W-1:0]     w_k;
    logic [2:0]              w_ks;
    logic                    w_sw_on;
    logic                    w_nonzero;
    logic [CTRL_W-1:0]       w_sw_ctrl;
    logic [CTRL_W-1:0]       w_pedal_cc;

    assign w_key_range = (i_event_code >= CODE_W'(FIRST_SWITCH_CODE))
                      && (i_event_code < CODE_W'(FIRST_SWITCH_CODE + NUM_SWITCHES));
    assign w_k       = SW_IDX_W'(i_event_code - CODE_W'(FIRST_SWITCH_CODE));
    assign w_ks      = w_k[2:0];
    assign w_sw_on   = w_key_range && (w_k < SW_IDX_W'(SW_REG_COUNT))
                    && i_cfg.sw_enable[w_ks];
    assign w_nonzero = (i_event_value != '0);
    assign w_sw_ctrl = i_cfg.sw_ctrls[CTRL_W * w_ks +: CTRL_W];

    fpmc_pedal_scale u_scale (
        .i_value    (i_event_value),
        .o_cc_value (w_pedal_cc)
    );

    always_comb begin
        o_res    = '0;
        n_toggle = r_toggle;
        n_last   = r_last;
        case (i_opcode)
            OP_KEY: begin
                if (w_sw_on) begin
                    o_res.controller = w_sw_ctrl;
                    if (i_cfg.sw_toggle[w_ks]) begin
                        if (w_nonzero) begin
                            n_toggle[w_ks] = ~r_toggle[w_ks];
                            o_res.hit      = 1'b1;
                            o_res.cc_value = n_toggle[w_ks] ? CC_MAX : CC_OFF;
                        end
                    end else begin
                        o_res.hit      = 1'b1;
                        o_res.cc_value = w_nonzero ? CC_MAX : CC_OFF;
                    end
                end
            end
            OP_AXIS: begin
                if ((i_event_code == CODE_W'(PEDAL_AXIS)) && (i_cfg.pedal_ctrl != '0)
                        && (i_event_value != r_last)) begin
                    n_last           = i_event_value;
                    o_res.hit        = 1'b1;
                    o_res.controller = i_cfg.pedal_ctrl;
                    o_res.cc_value   = w_pedal_cc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle <= '0;
            r_last   <= '0;
        end else if (i_fire) begin
            r_toggle <= n_toggle;
            r_last   <= n_last;
        end
    end

endmodule

/* src/footswitch_pedal_to_midi_cc.sv */
// Channel   Direction  Handshake              Payload
// request   in         i_in_valid/o_in_stall  i_opcode, i_event_code, i_event_value
// result    out        o_out_valid/i_out_stall o_channel, o_controller, o_cc_value
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle while o_in_stall is low; a request that hits yields a result,
// held first in the input register, then in the result register after one pass of decode logic.
// Synchronous active-low reset clears config, toggle states and last pedal value.
// A stalled result holds the result register; one more request waits in the
// input register before o_in_stall rises. Config writes always complete.
module footswitch_pedal_to_midi_cc
    import fpmc_pkg::*;
#(
    parameter int NUM_SWITCHES = NUM_SWITCHES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [CODE_W-1:0]       i_event_code,
    input  logic signed [VAL_W-1:0] i_event_value,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [CHAN_W-1:0]       o_channel,
    output logic [CTRL_W-1:0]       o_controller,
    output logic [CTRL_W-1:0]       o_cc_value,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg                    w_cfg;
    t_result                 w_res;
    logic                    w_adv;
    logic                    w_in_acc;
    logic                    w_out_load;

    logic                    r_in_vld;
    logic [OP_W-1:0]         r_in_op;
    logic [CODE_W-1:0]       r_in_code;
    logic signed [VAL_W-1:0] r_in_val;

    logic                    r_out_vld;
    logic [CHAN_W-1:0]       r_out_chan;
    logic [CTRL_W-1:0]       r_out_ctrl;
    logic [CTRL_W-1:0]       r_out_cc;

    fpmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    fpmc_event_core #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_fire        (w_adv),
        .i_opcode      (r_in_op),
        .i_event_code  (r_in_code),
        .i_event_value (r_in_val),
        .o_res         (w_res)
    );

    assign w_out_load = !r_out_vld || !i_out_stall;
    assign w_adv      = r_in_vld && w_out_load;
    assign o_in_stall = r_in_vld && r_out_vld && i_out_stall;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_op   <= i_opcode;
            r_in_code <= i_event_code;
            r_in_val  <= i_event_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= w_adv && w_res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_chan <= w_cfg.midi_channel;
            r_out_ctrl <= w_res.controller;
            r_out_cc   <= w_res.cc_value;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_channel    = r_out_chan;
    assign o_controller = r_out_ctrl;
    assign o_cc_value   = r_out_cc;

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld))
        else $error("request stalled without a held result");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_vld))
        else $error("valid survived reset");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_vld))
        else $error("result without a request");

    a_pedal_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_cc_value != CC_OFF && o_cc_value != CC_MAX)
            |-> (o_controller == w_cfg.pedal_ctrl))
        else $error("scaled value on a non-pedal controller");

endmodule
